// ===== hdl/scs_pkg.sv =====
// shared types, constants and helpers of the seed chain scorer
package scs_pkg;

  localparam int XW    = 36;
  localparam int ACC_W = 56;
  localparam int MW    = XW + 12;

  typedef enum logic [2:0] {
    REG_GAP_OPEN   = 3'd0,
    REG_GAP_EXTEND = 3'd1,
    REG_MATCH      = 3'd2,
    REG_KMER       = 3'd3,
    REG_CIRCULAR   = 3'd4
  } reg_index_t;

  typedef enum logic [4:0] {
    S_IDLE, S_LAST_RD, S_LAST_MUL, S_LAST_WR,
    S_I_RD, S_I_LD, S_I_MUL, S_I_INIT,
    S_J_RD, S_J_LD, S_J_MUL, S_J_CMP,
    S_NX_RD, S_NX_LD, S_E_RD, S_E_LD, S_E_OUT
  } state_t;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_LOAD, CMD_LAST_RD, CMD_LAST_MUL, CMD_LAST_WR,
    CMD_I_RD, CMD_I_LD, CMD_I_MUL, CMD_I_INIT,
    CMD_J_RD, CMD_J_LD, CMD_J_MUL, CMD_J_CMP,
    CMD_NX_RD, CMD_NX_LD, CMD_E_RD, CMD_E_LD, CMD_E_DONE
  } cmd_t;

  typedef struct packed {
    logic last_zero;
    logic i_zero;
    logic j_done;
    logic chain_end;
  } status_t;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(64'sh7FFF_FFFF);
    lo = -ACC_W'(64'sh8000_0000);
    if (v > hi) return 32'sh7FFF_FFFF;
    else if (v < lo) return 32'sh8000_0000;
    else return v[31:0];
  endfunction

  function automatic logic signed [XW-1:0] uext(input logic [30:0] v);
    return $signed({{(XW-31){1'b0}}, v});
  endfunction

  function automatic logic signed [XW-1:0] sabs(input logic signed [XW-1:0] v);
    return v < 0 ? -v : v;
  endfunction

endpackage

// ===== hdl/scs_ram.sv =====
// generic single write, single read ram with registered read
module scs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/scs_ctrl.sv =====
// sequencer for loading, chaining and chain emission
module scs_ctrl
  import scs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    last_seed,
  input  logic    out_ready,
  input  status_t status,
  output logic    in_ready,
  output logic    out_valid,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (in_valid && last_seed) state_next = S_LAST_RD;
      S_LAST_RD:  state_next = S_LAST_MUL;
      S_LAST_MUL: state_next = S_LAST_WR;
      S_LAST_WR:  state_next = status.last_zero ? S_E_RD : S_I_RD;
      S_I_RD:     state_next = S_I_LD;
      S_I_LD:     state_next = S_I_MUL;
      S_I_MUL:    state_next = S_I_INIT;
      S_I_INIT:   state_next = S_J_RD;
      S_J_RD:     state_next = status.j_done ? S_NX_RD : S_J_LD;
      S_J_LD:     state_next = S_J_MUL;
      S_J_MUL:    state_next = S_J_CMP;
      S_J_CMP:    state_next = S_J_RD;
      S_NX_RD:    state_next = S_NX_LD;
      S_NX_LD:    state_next = status.i_zero ? S_E_RD : S_I_RD;
      S_E_RD:     state_next = S_E_LD;
      S_E_LD:     state_next = S_E_OUT;
      S_E_OUT: begin
        if (out_ready) state_next = status.chain_end ? S_IDLE : S_E_RD;
      end
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = CMD_NONE;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd = CMD_LOAD;
      end
      S_LAST_RD:  cmd = CMD_LAST_RD;
      S_LAST_MUL: cmd = CMD_LAST_MUL;
      S_LAST_WR:  cmd = CMD_LAST_WR;
      S_I_RD:     cmd = CMD_I_RD;
      S_I_LD:     cmd = CMD_I_LD;
      S_I_MUL:    cmd = CMD_I_MUL;
      S_I_INIT:   cmd = CMD_I_INIT;
      S_J_RD:     cmd = CMD_J_RD;
      S_J_LD:     cmd = CMD_J_LD;
      S_J_MUL:    cmd = CMD_J_MUL;
      S_J_CMP:    cmd = CMD_J_CMP;
      S_NX_RD:    cmd = CMD_NX_RD;
      S_NX_LD:    cmd = CMD_NX_LD;
      S_E_RD:     cmd = CMD_E_RD;
      S_E_LD:     cmd = CMD_E_LD;
      S_E_OUT: begin
        out_valid = 1'b1;
        if (out_ready) cmd = CMD_E_DONE;
      end
      default:    cmd = CMD_NONE;
    endcase
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output open together");

  a_last_starts: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid && last_seed) |=> (state == S_LAST_RD))
    else $error("last seed did not start chaining");

  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped before accept");

endmodule

// ===== hdl/scs_dp.sv =====
// seed stores, chaining arithmetic and result registers
module scs_dp
  import scs_pkg::*;
#(
  parameter int MAX_SEEDS = 32,
  parameter int BAND      = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output status_t             status,
  input  logic                wr_en,
  input  logic [2:0]          wr_index,
  input  logic [11:0]         wr_data,
  input  logic [30:0]         target_start,
  input  logic [30:0]         target_end,
  input  logic [30:0]         query_start,
  input  logic [30:0]         query_end,
  input  logic [30:0]         seed_length,
  input  logic [30:0]         query_length,
  input  logic [30:0]         template_length,
  output logic [5:0]          seed_index,
  output logic signed [31:0]  chain_score,
  output logic signed [31:0]  chain_weight,
  output logic signed [31:0]  best_score,
  output logic signed [31:0]  second_score,
  output logic                last_in_chain
);

  localparam int IDX_W = $clog2(MAX_SEEDS);
  localparam int CNT_W = $clog2(MAX_SEEDS + 1);
  localparam int BCW   = $clog2(BAND + 1);
  localparam int GEO_W = 124;
  localparam int DYN_W = 64 + IDX_W;

  logic signed [11:0] gap_open, gap_extend;
  logic [10:0]        match_reward;
  logic [5:0]         kmer_size;
  logic               circular_mode;

  logic [CNT_W-1:0] count;
  logic [30:0]      qlen, tlen;
  logic signed [31:0] best, second;
  logic [IDX_W-1:0] pos, i, nx;
  logic [CNT_W-1:0] j;
  logic [BCW-1:0]   bcnt;

  logic [30:0] te_i, qe_i, ts_i;
  logic signed [31:0] w_i;
  logic signed [XW-1:0] e0;
  logic signed [MW-1:0] e_mul;
  logic signed [MW-1:0] w_mul;
  logic signed [ACC_W-1:0] cur;
  logic signed [XW-1:0] garg, pen;
  logic j_ok;
  logic signed [ACC_W-1:0] base;
  logic signed [MW-1:0] gmul, pmul;
  logic gzero, j_ok_m;
  logic [IDX_W-1:0] e_link;

  logic               geo_we, dyn_we;
  logic [IDX_W-1:0]   wr_addr, rd_addr;
  logic [GEO_W-1:0]   geo_wd, geo_rd;
  logic [DYN_W-1:0]   dyn_wd, dyn_rd;

  logic [30:0] r_ts, r_te, r_qs, r_qe;
  logic signed [31:0] r_w, r_s;
  logic [IDX_W-1:0] r_link;
  assign {r_ts, r_te, r_qs, r_qe} = geo_rd;
  assign {r_w, r_s, r_link} = dyn_rd;

  scs_ram #(.WIDTH(GEO_W), .DEPTH(MAX_SEEDS)) u_geo (
    .clk(clk), .wr_en(geo_we), .wr_addr(wr_addr), .wr_data(geo_wd),
    .rd_addr(rd_addr), .rd_data(geo_rd)
  );

  scs_ram #(.WIDTH(DYN_W), .DEPTH(MAX_SEEDS)) u_dyn (
    .clk(clk), .wr_en(dyn_we), .wr_addr(wr_addr), .wr_data(dyn_wd),
    .rd_addr(rd_addr), .rd_data(dyn_rd)
  );

  logic [IDX_W-1:0] last_idx;
  logic room;
  assign last_idx = IDX_W'(count - CNT_W'(1));
  assign room     = count < CNT_W'(MAX_SEEDS);

  // signed views
  logic signed [XW-1:0] k_s, tlen_s, qlen_s, te_s, qe_s;
  logic signed [11:0]   mr_s;
  assign k_s    = $signed({{(XW-6){1'b0}}, kmer_size});
  assign tlen_s = uext(tlen);
  assign qlen_s = uext(qlen);
  assign te_s   = uext(te_i);
  assign qe_s   = uext(qe_i);
  assign mr_s   = $signed({1'b0, match_reward});

  // link candidate geometry
  logic signed [XW-1:0] dtt, dqq, t0, tt, tej_te, qej_qe, ts_s;
  logic signed [XW-1:0] garg_c, pen_c;
  logic ok_c;
  always_comb begin
    ts_s   = uext(r_ts);
    dtt    = ts_s - te_s;
    dqq    = uext(r_qs) - qe_s;
    tej_te = uext(r_te) - te_s;
    qej_qe = uext(r_qe) - qe_s;
    t0     = ts_s + qe_s - uext(r_qs);
    tt     = (circular_mode && tlen_s < t0) ? t0 - tlen_s : t0;
    garg_c = '0;
    pen_c  = '0;
    ok_c   = 1'b0;
    if (qe_i < r_qs) begin
      if (te_i < r_ts) begin
        garg_c = sabs(dtt - dqq);
        ok_c   = 1'b1;
      end else if (k_s <= tej_te) begin
        garg_c = dqq;
        pen_c  = dtt;
        ok_c   = 1'b1;
      end else if (circular_mode && r_te < ts_i) begin
        garg_c = sabs((tlen_s - te_s + ts_s) - dqq);
        ok_c   = 1'b1;
      end
    end else if (k_s <= qej_qe) begin
      if (te_s < tt) begin
        garg_c = tt - te_s;
        pen_c  = tt - te_s;
        ok_c   = 1'b1;
      end else if (circular_mode && te_s != tt) begin
        garg_c = tlen_s - te_s + tt;
        pen_c  = te_s - tt;
        ok_c   = 1'b1;
      end
    end
  end

  logic signed [XW-1:0] e_min;
  assign e_min = ((qlen_s - qe_s) < (tlen_s - te_s)) ? (qlen_s - qe_s)
                                                     : (tlen_s - te_s);

  logic signed [ACC_W-1:0] ecost, gcand;
  logic signed [31:0] sc_new, wt_new;
  logic signed [33:0] wsum;
  always_comb begin
    if (e0 > 0)       ecost = ACC_W'(e_mul) + ACC_W'(gap_open);
    else if (e0 == 0) ecost = ACC_W'(gap_open);
    else              ecost = '0;
    gcand  = (gzero ? ACC_W'(0) : ACC_W'(gmul) + ACC_W'(gap_open)) + base - ACC_W'(pmul);
    sc_new = sat32(cur);
    wsum   = 34'(w_i) + ((nx != '0) ? 34'(r_w) : 34'sd0)
             - $signed({28'd0, kmer_size}) + 34'sd1;
    wt_new = sat32(ACC_W'(wsum));
  end

  // memory ports
  always_comb begin
    geo_we  = 1'b0;
    dyn_we  = 1'b0;
    wr_addr = IDX_W'(count);
    geo_wd  = {target_start, target_end, query_start, query_end};
    dyn_wd  = {$signed({1'b0, seed_length}), 32'sd0, {IDX_W{1'b0}}};
    rd_addr = pos;
    unique case (cmd)
      CMD_LOAD: begin
        geo_we = room;
        dyn_we = room;
      end
      CMD_LAST_WR: begin
        dyn_we  = 1'b1;
        wr_addr = last_idx;
        dyn_wd  = {sat32(ACC_W'(w_i) - ACC_W'($signed({1'b0, kmer_size})) + ACC_W'(1)),
                   sat32(ACC_W'(w_mul)), {IDX_W{1'b0}}};
      end
      CMD_NX_LD: begin
        dyn_we  = 1'b1;
        wr_addr = i;
        dyn_wd  = {wt_new, sc_new, nx};
      end
      CMD_LAST_RD: rd_addr = last_idx;
      CMD_I_RD:    rd_addr = i;
      CMD_J_RD:    rd_addr = IDX_W'(j);
      CMD_NX_RD:   rd_addr = nx;
      default:     rd_addr = pos;
    endcase
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      gap_open      <= -12'sd3;
      gap_extend    <= -12'sd1;
      match_reward  <= 11'd1;
      kmer_size     <= 6'd16;
      circular_mode <= 1'b0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_GAP_OPEN:   gap_open      <= $signed(wr_data);
        REG_GAP_EXTEND: gap_extend    <= $signed(wr_data);
        REG_MATCH:      match_reward  <= wr_data[10:0];
        REG_KMER:       kmer_size     <= wr_data[5:0];
        REG_CIRCULAR:   circular_mode <= wr_data[0];
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      qlen   <= '0;
      tlen   <= '0;
      best   <= '0;
      second <= '0;
      pos    <= '0;
    end else begin
      unique case (cmd)
        CMD_LOAD: begin
          qlen <= query_length;
          tlen <= template_length;
          if (room) count <= count + CNT_W'(1);
        end
        CMD_LAST_WR: begin
          best   <= sat32(ACC_W'(w_mul));
          second <= '0;
          pos    <= last_idx;
        end
        CMD_NX_LD: begin
          if (best < sc_new) begin
            if (nx != pos) second <= best;
            best <= sc_new;
            pos  <= i;
          end else if (best == sc_new && nx != pos) begin
            second <= best;
          end
        end
        CMD_E_DONE: begin
          if (last_in_chain) count <= '0;
          else pos <= e_link;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (cmd)
      CMD_LAST_MUL: begin
        w_i   <= r_w;
        w_mul <= MW'(r_w * mr_s);
      end
      CMD_LAST_WR: i <= last_idx - IDX_W'(1);
      CMD_I_LD: begin
        te_i <= r_te;
        qe_i <= r_qe;
        ts_i <= r_ts;
        w_i  <= r_w;
      end
      CMD_I_MUL: begin
        e0    <= e_min - XW'(1);
        w_mul <= MW'(w_i * mr_s);
      end
      CMD_I_INIT: begin
        e_mul <= MW'(e0 * gap_extend);
      end
      CMD_J_LD: begin
        garg <= garg_c;
        pen  <= pen_c;
        j_ok <= ok_c;
        base <= ACC_W'(w_mul) + ACC_W'(r_s);
      end
      CMD_J_MUL: begin
        gmul   <= MW'((garg - XW'(1)) * gap_extend);
        pmul   <= MW'(pen * mr_s);
        gzero  <= garg == '0;
        j_ok_m <= j_ok;
      end
      CMD_J_CMP: begin
        if (j_ok_m && cur < gcand) begin
          cur <= gcand;
          nx  <= IDX_W'(j);
        end
        j    <= j + CNT_W'(1);
        bcnt <= bcnt + BCW'(1);
      end
      CMD_NX_LD: if (i != '0) i <= i - IDX_W'(1);
      CMD_E_LD: begin
        seed_index    <= 6'(pos);
        chain_score   <= r_s;
        chain_weight  <= r_w;
        best_score    <= best;
        second_score  <= second;
        e_link        <= r_link;
        last_in_chain <= (r_link == '0) || (r_link <= pos)
                         || (CNT_W'(r_link) >= count);
      end
      default: ;
    endcase
    // the e cost product seeds cur in the first candidate read state, before the first compare
    if (cmd == CMD_J_RD && j == CNT_W'(i) + CNT_W'(1)) begin
      cur <= ecost + ACC_W'(w_mul);
      nx  <= '0;
    end
    if (cmd == CMD_I_INIT) begin
      j    <= CNT_W'(i) + CNT_W'(1);
      bcnt <= BCW'(1);
      cur  <= '0;
    end
  end

  always_comb begin
    status.last_zero = count == CNT_W'(1);
    status.i_zero    = i == '0;
    status.j_done    = !((j < count) && (bcnt < BCW'(BAND)));
    status.chain_end = last_in_chain;
  end

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_SEEDS))
    else $error("seed count above capacity");

  a_j_ahead: assert property (@(posedge clk) disable iff (rst)
    (cmd == CMD_J_LD) |-> (CNT_W'(i) < j))
    else $error("candidate not after current seed");

  a_link_fwd: assert property (@(posedge clk) disable iff (rst)
    (cmd == CMD_NX_LD && nx != '0) |-> (nx > i))
    else $error("link points backward");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (cmd == CMD_E_RD) |-> (CNT_W'(pos) < count))
    else $error("emit position outside stored seeds");

endmodule

// ===== hdl/seed_chain_scorer_core.sv =====
// Seed loading: one beat per cycle while idle; a beat with last_seed starts chaining.
// Chaining: the last seed first, then each earlier seed against the candidates in its band,
// one candidate at a time through the shared compare unit and the single store read port.
// Emission: each result beat is read from the store and held until out_ready; input is held off meanwhile.
// Synchronous active-high reset restores the register defaults and empties the job.
module seed_chain_scorer_core
  import scs_pkg::*;
#(
  parameter int MAX_SEEDS = 32,
  parameter int BAND      = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [2:0]         wr_index,
  input  logic [11:0]        wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [30:0]        target_start,
  input  logic [30:0]        target_end,
  input  logic [30:0]        query_start,
  input  logic [30:0]        query_end,
  input  logic [30:0]        seed_length,
  input  logic [30:0]        query_length,
  input  logic [30:0]        template_length,
  input  logic               last_seed,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         seed_index,
  output logic signed [31:0] chain_score,
  output logic signed [31:0] chain_weight,
  output logic signed [31:0] best_score,
  output logic signed [31:0] second_score,
  output logic               last_in_chain
);

  cmd_t    cmd;
  status_t status;

  scs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .last_seed(last_seed),
    .out_ready(out_ready), .status(status), .in_ready(in_ready),
    .out_valid(out_valid), .cmd(cmd)
  );

  scs_dp #(.MAX_SEEDS(MAX_SEEDS), .BAND(BAND)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .target_start(target_start), .target_end(target_end),
    .query_start(query_start), .query_end(query_end),
    .seed_length(seed_length), .query_length(query_length),
    .template_length(template_length),
    .seed_index(seed_index), .chain_score(chain_score),
    .chain_weight(chain_weight), .best_score(best_score),
    .second_score(second_score), .last_in_chain(last_in_chain)
  );

endmodule

// ===== dv/seed_chain_scorer_core_tb.sv =====
// self-checking testbench of the seed chain scorer: directed table, then random jobs
`timescale 1ns / 100ps
module seed_chain_scorer_core_tb;
  import scs_pkg::*;

  localparam int NSEEDS    = 32;
  localparam int NBAND     = 64;
  localparam int IDLE_LIMIT = 40000;
  localparam int HOLD_LEN  = 400;

  typedef struct {
    logic [30:0] ts, te, qs, qe, len, qlen, tlen;
    logic        last;
  } seed_t;

  typedef struct {
    logic [5:0]         idx;
    logic signed [31:0] score, weight, best, second;
    logic               last;
  } chain_beat_t;

  typedef struct {
    seed_t              s;
    bit                 typed;
    logic signed [31:0] score, weight;
  } row_t;

  logic clk = 0, rst = 1;
  logic wr_en = 0;
  logic [2:0] wr_index = '0;
  logic [11:0] wr_data = '0;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  logic [30:0] target_start = '0, target_end = '0, query_start = '0, query_end = '0;
  logic [30:0] seed_length = '0, query_length = '0, template_length = '0;
  logic last_seed = 0;
  logic [5:0] seed_index;
  logic signed [31:0] chain_score, chain_weight, best_score, second_score;
  logic last_in_chain;

  seed_chain_scorer_core i_dut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // predictor state
  longint p_go = -3, p_ge = -1, p_mr = 1, p_km = 16;
  bit p_circ = 0;
  longint p_ts[NSEEDS], p_te[NSEEDS], p_qs[NSEEDS], p_qe[NSEEDS];
  int p_w[NSEEDS], p_sc[NSEEDS];
  int unsigned p_link[NSEEDS];
  int unsigned p_cnt = 0;
  longint p_qlen = 0, p_tlen = 0;
  int p_best, p_second;
  int unsigned p_bpos;

  chain_beat_t chain_q[$];
  int fails = 0;
  int idle_cycles = 0;
  int vld_idle_pct = 0, rdy_idle_pct = 0;
  bit hold_req = 0;
  int hold_cnt = 0;

  function automatic int sat(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return int'(v);
  endfunction

  function automatic longint gap_score(longint g);
    if (g == 0) return 0;
    return (g - 1) * p_ge + p_go;
  endfunction

  function automatic longint labs(longint a);
    return a < 0 ? -a : a;
  endfunction

  task automatic score_chain();
    int n, lst, jmax;
    int unsigned nx, pos, steps;
    longint w, te, qe, tsi, e, cur, g, ts, tej, qs, qej, base, t;
    int sc;
    bit ok, fin;
    chain_beat_t b;
    n = p_cnt;
    lst = n - 1;
    p_sc[lst] = sat(longint'(p_w[lst]) * p_mr);
    p_link[lst] = 0;
    p_w[lst] = sat(longint'(p_w[lst]) - (p_km - 1));
    p_best = p_sc[lst];
    p_second = 0;
    p_bpos = lst;
    for (int i = lst - 1; i >= 0; i--) begin
      w = longint'(p_w[i]) * p_mr;
      te = p_te[i];
      qe = p_qe[i];
      tsi = p_ts[i];
      e = p_tlen - te;
      if (p_qlen - qe < e) e = p_qlen - qe;
      e -= 1;
      if (e > 0) e = e * p_ge + p_go;
      else if (e == 0) e = p_go;
      else e = 0;
      cur = e + w;
      nx = 0;
      jmax = i + NBAND;
      if (jmax > n) jmax = n;
      for (int j = i + 1; j < jmax; j++) begin
        ts = p_ts[j]; tej = p_te[j]; qs = p_qs[j]; qej = p_qe[j];
        base = w + p_sc[j];
        ok = 0;
        g = 0;
        if (qe < qs) begin
          if (te < ts) begin
            g = gap_score(labs((ts - te) - (qs - qe))) + base; ok = 1;
          end else if (p_km <= tej - te) begin
            g = gap_score(qs - qe) + base - (ts - te) * p_mr; ok = 1;
          end else if (p_circ && tej < tsi) begin
            g = gap_score(labs((p_tlen - te + ts) - (qs - qe))) + base; ok = 1;
          end
        end else if (p_km <= qej - qe) begin
          t = ts + qe - qs;
          if (p_circ && p_tlen < t) t -= p_tlen;
          if (te < t) begin
            g = gap_score(t - te) + base - (t - te) * p_mr; ok = 1;
          end else if (p_circ && te != t) begin
            g = gap_score(p_tlen - te + t) + base - (te - t) * p_mr; ok = 1;
          end
        end
        if (ok && cur < g) begin
          cur = g;
          nx = j;
        end
      end
      if (nx != 0) p_w[i] = sat(longint'(p_w[i]) + p_w[nx] - p_km + 1);
      else p_w[i] = sat(longint'(p_w[i]) - (p_km - 1));
      sc = sat(cur);
      p_sc[i] = sc;
      p_link[i] = nx;
      if (p_best < sc) begin
        if (nx != p_bpos) p_second = p_best;
        p_best = sc;
        p_bpos = i;
      end else if (p_best == sc && nx != p_bpos) begin
        p_second = p_best;
      end
    end
    pos = p_bpos;
    steps = 0;
    while (pos < p_cnt && steps < p_cnt) begin
      nx = p_link[pos];
      fin = (nx == 0) || (nx <= pos) || (nx >= p_cnt);
      b.idx = pos[5:0];
      b.score = p_sc[pos];
      b.weight = p_w[pos];
      b.best = p_best;
      b.second = p_second;
      b.last = fin;
      chain_q.push_back(b);
      steps++;
      if (fin) break;
      pos = nx;
    end
  endtask

  // returns 1 if the beat closed a job
  function automatic bit load_seed(seed_t s);
    p_qlen = s.qlen;
    p_tlen = s.tlen;
    if (p_cnt < NSEEDS) begin
      p_ts[p_cnt] = s.ts; p_te[p_cnt] = s.te;
      p_qs[p_cnt] = s.qs; p_qe[p_cnt] = s.qe;
      p_w[p_cnt] = int'({1'b0, s.len});
      p_cnt++;
    end
    return s.last;
  endfunction

  task automatic send_seed(seed_t s, bit typed = 0, int tscore = 0, int tweight = 0);
    chain_beat_t b;
    @(negedge clk);
    if (vld_idle_pct > 0 && $urandom_range(99) < vld_idle_pct) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid <= 1;
    target_start <= s.ts; target_end <= s.te;
    query_start <= s.qs; query_end <= s.qe;
    seed_length <= s.len; query_length <= s.qlen;
    template_length <= s.tlen; last_seed <= s.last;
    do begin
      @(posedge clk);
    end while (!in_ready);
    if (load_seed(s)) begin
      if (typed) begin
        p_cnt = 0;
        b.idx = 0; b.score = tscore; b.weight = tweight;
        b.best = tscore; b.second = 0; b.last = 1;
        chain_q.push_back(b);
      end else begin
        score_chain();
        p_cnt = 0;
      end
    end
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_valid <= 0;
  endtask

  task automatic drain();
    stop_sending();
    wait (chain_q.size() == 0);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_regs(int go, int ge, int mr, int km, int circ);
    logic [11:0] v[5];
    v[0] = go[11:0]; v[1] = ge[11:0]; v[2] = mr[11:0]; v[3] = km[11:0]; v[4] = circ[11:0];
    for (int r = 0; r < 5; r++) begin
      @(negedge clk);
      wr_en <= 1;
      wr_index <= reg_index_t'(r);
      wr_data <= v[r];
    end
    p_go = longint'($signed(v[0]));
    p_ge = longint'($signed(v[1]));
    p_mr = v[2][10:0];
    p_km = v[3][5:0];
    p_circ = v[4][0];
    @(negedge clk);
    wr_en <= 0;
  endtask

  function automatic seed_t noise_seed(bit last);
    seed_t s;
    s.ts = 31'($urandom); s.te = 31'($urandom); s.qs = 31'($urandom); s.qe = 31'($urandom);
    s.len = 31'($urandom); s.qlen = 31'($urandom); s.tlen = 31'($urandom); s.last = last;
    return s;
  endfunction

  // seeds mostly in ascending order with small gaps, so that links of every kind come up
  task automatic random_job(ref int sent);
    int n;
    logic [30:0] tp, qp, ql, tl;
    seed_t s;
    bit wild;
    n = ($urandom_range(14) == 0) ? $urandom_range(33, 36) : $urandom_range(1, 7);
    wild = ($urandom_range(9) == 0);
    tp = 31'($urandom_range(0, 2000));
    qp = 31'($urandom_range(0, 200));
    tl = $urandom_range(9) == 0 ? 31'h7FFF_FFFF : 31'($urandom_range(1000, 5000));
    ql = $urandom_range(9) == 0 ? 31'h7FFF_FFFF : 31'($urandom_range(100, 600));
    for (int k = 0; k < n; k++) begin
      if (wild && $urandom_range(2) == 0) begin
        s = noise_seed(k == n - 1);
      end else begin
        s.len = 31'($urandom_range(0, 40));
        s.ts = tp; s.qs = qp;
        s.te = tp + s.len; s.qe = qp + s.len;
        if ($urandom_range(5) == 0) s.ts = 31'(tp % 500);
        s.qlen = ql; s.tlen = tl; s.last = (k == n - 1);
        tp = tp + 31'($urandom_range(0, 60));
        qp = ($urandom_range(7) == 0) ? qp - 31'($urandom_range(0, 20))
                                      : qp + 31'($urandom_range(0, 60));
      end
      send_seed(s);
      sent++;
    end
  endtask

  always @(negedge clk) begin
    if (hold_req) begin
      hold_cnt = HOLD_LEN;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 0;
    end else begin
      out_ready <= !(rdy_idle_pct > 0 && $urandom_range(99) < rdy_idle_pct);
    end
  end

  // sample at the rising edge
  always @(posedge clk) begin
    chain_beat_t b;
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
      if (out_valid && out_ready) begin
        if (chain_q.size() == 0) begin
          $display("%0t: unexpected result beat, seed_index %0d", $time, seed_index);
          fails++;
        end else begin
          b = chain_q.pop_front();
          if (seed_index !== b.idx || chain_score !== b.score || chain_weight !== b.weight
              || best_score !== b.best || second_score !== b.second
              || last_in_chain !== b.last) begin
            $display("%0t: mismatch exp idx %0d sc %0d w %0d best %0d sec %0d last %0d",
                     $time, b.idx, b.score, b.weight, b.best, b.second, b.last);
            $display("%0t:          act idx %0d sc %0d w %0d best %0d sec %0d last %0d",
                     $time, seed_index, chain_score, chain_weight, best_score,
                     second_score, last_in_chain);
            fails++;
          end
        end
      end
    end
  end

  row_t rows[$];

  function automatic seed_t mk(longint ts, longint te, longint qs, longint qe, longint len,
                               longint ql, longint tl, bit last);
    seed_t s;
    s.ts = 31'(ts); s.te = 31'(te); s.qs = 31'(qs); s.qe = 31'(qe); s.len = 31'(len);
    s.qlen = 31'(ql); s.tlen = 31'(tl); s.last = last;
    return s;
  endfunction

  task automatic add_row(seed_t s, bit typed = 0, int sc = 0, int w = 0);
    row_t r;
    r.s = s; r.typed = typed; r.score = sc; r.weight = w;
    rows.push_back(r);
  endtask

  initial begin
    int sent;
    int cfg[5][5];
    cfg = '{'{-1024, -1024, 1024, 1, 1},
            '{2047, -2048, 2047, 63, 0},
            '{0, 0, 0, 0, 1},
            '{-3, -1, 2, 12, 1},
            '{1024, 1024, 0, 32, 0}};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // single-seed jobs at reset settings, read off directly
    add_row(mk(0, 0, 0, 0, 31'h7FFF_FFFF, 0, 0, 1), 1, 32'sh7FFF_FFFF, 32'sd2147483632);
    add_row(mk(0, 0, 0, 0, 0, 0, 0, 1), 1, 0, -15);
    add_row(mk('1, '1, '1, '1, 16, '1, '1, 1), 1, 16, 1);
    // full link, semi link by target overlap, query overlap
    add_row(mk(10, 30, 5, 25, 20, 300, 1000, 0));
    add_row(mk(50, 70, 40, 60, 20, 300, 1000, 0));
    add_row(mk(60, 90, 70, 100, 30, 300, 1000, 0));
    add_row(mk(100, 130, 90, 120, 30, 300, 1000, 1));
    // query-cut link, then wrap-around candidates under default mode
    add_row(mk(200, 240, 10, 50, 40, 400, 2000, 0));
    add_row(mk(230, 260, 30, 60, 30, 400, 2000, 0));
    add_row(mk(5, 30, 80, 105, 25, 400, 2000, 0));
    add_row(mk(1900, 1990, 150, 240, 90, 400, 2000, 1));
    // wide coordinates and lengths
    add_row(mk(0, 31'h7FFF_FFF0, 0, 31'h7FFF_FFF0, 31'h7FFF_FFFF, '1, '1, 0));
    add_row(mk(31'h7FFF_FFF8, '1, 31'h7FFF_FFF8, '1, 31'h7FFF_FFFF, '1, '1, 1));
    foreach (rows[r]) send_seed(rows[r].s, rows[r].typed, rows[r].score, rows[r].weight);
    drain();

    // register extremes, each with two short directed jobs
    for (int c = 0; c < 5; c++) begin
      set_regs(cfg[c][0], cfg[c][1], cfg[c][2], cfg[c][3], cfg[c][4]);
      for (int k = 0; k < 4; k++) send_seed(rows[3 + k].s);
      for (int k = 0; k < 4; k++) send_seed(rows[7 + k].s);
      drain();
    end

    sent = 0;
    for (int ph = 0; ph < 3; ph++) begin
      vld_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 69 : 0;
      rdy_idle_pct = (ph == 0) ? 69 : (ph == 1) ? 33 : 0;
      set_regs(cfg[3][0], cfg[3][1], cfg[3][2], cfg[3][3], cfg[3][4]);
      if (ph == 2) hold_req = 1;
      while (sent < 27 * (2 * ph + 1)) begin
        random_job(sent);
        if (ph == 1 && sent > 90 && sent < 100) begin
          stop_sending();
          wait (chain_q.size() == 0);
        end
      end
      drain();
      set_regs($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 2047),
               $urandom_range(0, 63), $urandom_range(0, 1));
      while (sent < 27 * (2 * ph + 2)) random_job(sent);
      drain();
    end

    repeat (100) @(posedge clk);
    if (fails == 0 && chain_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/scs_pkg.sv
hdl/scs_ram.sv
hdl/scs_ctrl.sv
hdl/scs_dp.sv
hdl/seed_chain_scorer_core.sv
dv/seed_chain_scorer_core_tb.sv
